/* hdl/fr_fcfs_bank_request_scheduler_unit_defines.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the FR-FCFS bank request scheduler
// Define NO_ASSERTIONS to compile every check away.
// -----------------------------------------------------------------------------
`ifndef FR_FCFS_BANK_REQUEST_SCHEDULER_UNIT_DEFINES_SVH
`define FR_FCFS_BANK_REQUEST_SCHEDULER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl : assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl : assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl : assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hdl/frfcfs_pkg.sv */
// -----------------------------------------------------------------------------
// frfcfs_pkg
// Field widths, codes and control structs shared by the scheduler modules.
// -----------------------------------------------------------------------------
package frfcfs_pkg;

   localparam int MODE_W      = 2;
   localparam int BANK_FLD_W  = 4;
   localparam int ROW_W       = 16;
   localparam int TAG_FLD_W   = 8;
   localparam int STATUS_W    = 2;
   localparam int COUNT_FLD_W = 5;

   localparam int NUM_BANKS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TAG_BITS_DEF    = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_STORE  = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_SELECT = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic store;
      logic scan;
      logic shift;
      logic commit;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      mode_type mode;
      logic     bad;
      logic     empty;
      logic     open;
      logic     first;
      logic     row_eq;
      logic     tag_eq;
      logic     last;
      logic     drain;
      logic     out_free;
   } stat_type;

endpackage

/* hdl/frfcfs_ctrl.sv */
// -----------------------------------------------------------------------------
// frfcfs_ctrl
// Sequencer: takes one request, walks the bank queue and hands out the result.
// -----------------------------------------------------------------------------
`include "fr_fcfs_bank_request_scheduler_unit_defines.svh"

module frfcfs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  frfcfs_pkg::stat_type st_i,
   output frfcfs_pkg::cmd_type  cmd_o
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_SHIFT,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd_o     = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.load = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (st_i.bad || st_i.mode == frfcfs_pkg::MODE_STORE) begin
               cmd_o.store = (st_i.mode == frfcfs_pkg::MODE_STORE);
               state_in    = S_FINISH;
            end else if (st_i.empty) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd_o.scan = 1'b1;
            unique case (st_i.mode)
               frfcfs_pkg::MODE_REMOVE: begin
                  priority if (st_i.tag_eq) begin
                     state_in = S_SHIFT;
                  end else if (st_i.last) begin
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               frfcfs_pkg::MODE_SELECT: begin
                  // closed bank takes the head; open bank stops at the first row hit
                  if ((st_i.first && !st_i.open) || (st_i.open && st_i.row_eq) ||
                      st_i.last) begin
                     state_in = S_FINISH;
                  end
               end
               frfcfs_pkg::MODE_QUERY: begin
                  if (st_i.last) begin
                     state_in = S_FINISH;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SHIFT: begin
            if (st_i.drain) begin
               cmd_o.commit = 1'b1;
               state_in     = S_FINISH;
            end else begin
               cmd_o.shift = 1'b1;
            end
         end
         S_FINISH: begin
            if (st_i.out_free) begin
               cmd_o.emit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_ALWAYS(a_cmd_onehot, clock, reset, $onehot0({cmd_o.load, cmd_o.store, cmd_o.commit, cmd_o.emit}))
   `ASSERT_NEXT(a_load_decide, clock, reset, cmd_o.load, state_ff == S_DECIDE)
   `ASSERT_NEXT(a_emit_idle, clock, reset, cmd_o.emit, state_ff == S_IDLE && req_ready)

endmodule

/* hdl/frfcfs_dp.sv */
// -----------------------------------------------------------------------------
// frfcfs_dp
// Queue storage, per-bank counts, scan/shift pointers and the result register.
// -----------------------------------------------------------------------------
`include "fr_fcfs_bank_request_scheduler_unit_defines.svh"

module frfcfs_dp #(
   parameter int NUM_BANKS   = frfcfs_pkg::NUM_BANKS_DEF,
   parameter int QUEUE_DEPTH = frfcfs_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = frfcfs_pkg::TAG_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [frfcfs_pkg::MODE_W-1:0]       req_mode,
   input  logic [frfcfs_pkg::BANK_FLD_W-1:0]   req_bank,
   input  logic [frfcfs_pkg::ROW_W-1:0]        req_row,
   input  logic [frfcfs_pkg::TAG_FLD_W-1:0]    req_request_tag,
   input  logic                                req_bank_open,
   input  frfcfs_pkg::cmd_type                 cmd_i,
   output frfcfs_pkg::stat_type                st_o,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [frfcfs_pkg::STATUS_W-1:0]     rsp_status,
   output logic [frfcfs_pkg::TAG_FLD_W-1:0]    rsp_chosen_tag,
   output logic                                rsp_row_hit,
   output logic [frfcfs_pkg::COUNT_FLD_W-1:0]  rsp_entry_count
);

   localparam int BANK_W  = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
   localparam int SLOTS   = NUM_BANKS * QUEUE_DEPTH;
   localparam int ADDR_W  = $clog2(SLOTS);
   localparam int ROW_W   = frfcfs_pkg::ROW_W;
   localparam int ENTRY_W = ROW_W + TAG_BITS;
   localparam int TFLD_W  = frfcfs_pkg::TAG_FLD_W;
   localparam int CFLD_W  = frfcfs_pkg::COUNT_FLD_W;

   // queue storage, row above tag
   logic [ENTRY_W-1:0] mem [SLOTS];
   logic [ENTRY_W-1:0] rd_ff;

   logic [CNT_W-1:0]   count_ff [NUM_BANKS];

   frfcfs_pkg::mode_type   mode_ff;
   frfcfs_pkg::status_type status_ff;
   frfcfs_pkg::status_type status_in;
   logic [BANK_W-1:0]   bank_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic                open_ff;
   logic                bad_ff;
   logic [CNT_W-1:0]    n_ff;
   logic [CNT_W-1:0]    idx_ff;
   logic [CNT_W-1:0]    pos_ff;
   logic [CNT_W-1:0]    wr_ff;
   logic                rv_ff;
   logic                seen_ff;
   logic [TAG_BITS-1:0] chosen_ff;
   logic                hit_ff;

   logic                   rsp_valid_ff;
   frfcfs_pkg::status_type rsp_status_ff;
   logic [TFLD_W-1:0]      rsp_tag_ff;
   logic                   rsp_hit_ff;
   logic [CFLD_W-1:0]      rsp_count_ff;

   logic                       bank_ok;
   logic [BANK_W-1:0]          req_bank_idx;
   logic [CNT_W-1:0]           cur_count;
   logic                       full_now;
   logic [TAG_BITS+TFLD_W-1:0] tag_wide;
   logic [TAG_BITS-1:0]        tag_in;
   frfcfs_pkg::mode_type       mode_in;
   logic                       full;
   logic                       step;
   logic                       issue;
   logic [ADDR_W-1:0]          base;
   logic [ADDR_W-1:0]          rd_addr;
   logic [ADDR_W-1:0]          wr_addr;
   logic                       wr_en;
   logic [ENTRY_W-1:0]         wr_data;
   logic [ROW_W-1:0]           rd_row;
   logic [TAG_BITS-1:0]        rd_tag;
   logic                       row_eq;
   logic                       tag_eq;
   logic [TAG_BITS+TFLD_W-1:0] chosen_wide;
   logic [CNT_W+CFLD_W-1:0]    count_wide;

   assign bank_ok      = (int'(req_bank) < NUM_BANKS);
   assign req_bank_idx = BANK_W'(req_bank);
   assign cur_count    = bank_ok ? count_ff[req_bank_idx] : '0;
   assign full_now     = (cur_count >= CNT_W'(QUEUE_DEPTH));
   assign tag_wide     = {{TAG_BITS{1'b0}}, req_request_tag};
   assign tag_in       = tag_wide[TAG_BITS-1:0];
   assign mode_in      = frfcfs_pkg::mode_type'(req_mode);

   always_comb begin
      priority if (!bank_ok) begin
         status_in = frfcfs_pkg::STATUS_MISS;
      end else begin
         unique case (mode_in)
            frfcfs_pkg::MODE_STORE:
               status_in = full_now ? frfcfs_pkg::STATUS_FULL : frfcfs_pkg::STATUS_DONE;
            frfcfs_pkg::MODE_REMOVE:
               status_in = frfcfs_pkg::STATUS_MISS;
            frfcfs_pkg::MODE_SELECT:
               status_in = (cur_count == '0) ? frfcfs_pkg::STATUS_MISS
                                             : frfcfs_pkg::STATUS_DONE;
            default:
               status_in = frfcfs_pkg::STATUS_DONE;
         endcase
      end
   end

   assign full    = (n_ff >= CNT_W'(QUEUE_DEPTH));
   assign step    = cmd_i.scan | cmd_i.shift;
   assign issue   = (idx_ff < n_ff);
   assign base    = ADDR_W'(int'(bank_ff) * QUEUE_DEPTH);
   assign rd_addr = base + ADDR_W'(idx_ff[SLOT_W-1:0]);
   assign wr_addr = cmd_i.store ? base + ADDR_W'(n_ff[SLOT_W-1:0])
                                : base + ADDR_W'(wr_ff[SLOT_W-1:0]);
   assign wr_en   = (cmd_i.store & ~bad_ff & ~full) | (cmd_i.shift & rv_ff);
   assign wr_data = cmd_i.store ? {row_ff, tag_ff} : rd_ff;

   assign rd_row = rd_ff[ENTRY_W-1:TAG_BITS];
   assign rd_tag = rd_ff[TAG_BITS-1:0];
   assign row_eq = rv_ff && (rd_row == row_ff);
   assign tag_eq = rv_ff && (rd_tag == tag_ff);

   assign st_o.mode     = mode_ff;
   assign st_o.bad      = bad_ff;
   assign st_o.empty    = (n_ff == '0);
   assign st_o.open     = open_ff;
   assign st_o.first    = rv_ff && (pos_ff == '0);
   assign st_o.row_eq   = row_eq;
   assign st_o.tag_eq   = tag_eq;
   assign st_o.last     = rv_ff && ((pos_ff + CNT_W'(1)) == n_ff);
   assign st_o.drain    = !rv_ff && !issue;
   assign st_o.out_free = !rsp_valid_ff || rsp_ready;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (step && issue) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BANKS; b++) begin
            count_ff[b] <= '0;
         end
      end else begin
         if (cmd_i.load) begin
            rv_ff <= 1'b0;
         end else if (step) begin
            rv_ff <= issue;
         end
         if (cmd_i.store && !bad_ff && !full) begin
            count_ff[bank_ff] <= n_ff + CNT_W'(1);
         end
         if (cmd_i.commit && !bad_ff) begin
            count_ff[bank_ff] <= n_ff - CNT_W'(1);
         end
         if (cmd_i.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         mode_ff   <= mode_in;
         bank_ff   <= req_bank_idx;
         row_ff    <= req_row;
         tag_ff    <= tag_in;
         open_ff   <= req_bank_open;
         bad_ff    <= !bank_ok;
         n_ff      <= cur_count;
         status_ff <= status_in;
         idx_ff    <= '0;
         chosen_ff <= '0;
         hit_ff    <= 1'b0;
         seen_ff   <= 1'b0;
      end else begin
         if (step) begin
            pos_ff <= idx_ff;
            if (issue) begin
               idx_ff <= idx_ff + CNT_W'(1);
            end
         end
         if (cmd_i.store && !bad_ff && !full) begin
            n_ff <= n_ff + CNT_W'(1);
         end
         if (cmd_i.commit) begin
            n_ff      <= n_ff - CNT_W'(1);
            status_ff <= frfcfs_pkg::STATUS_DONE;
         end
         if (cmd_i.scan && rv_ff) begin
            unique case (mode_ff)
               frfcfs_pkg::MODE_SELECT: begin
                  if (open_ff && row_eq) begin
                     chosen_ff <= rd_tag;
                     hit_ff    <= 1'b1;
                  end else if (pos_ff == '0) begin
                     chosen_ff <= rd_tag;
                  end
               end
               frfcfs_pkg::MODE_QUERY: begin
                  if (row_eq) begin
                     if (seen_ff) begin
                        hit_ff <= 1'b1;
                     end
                     seen_ff <= 1'b1;
                  end
               end
               frfcfs_pkg::MODE_REMOVE: begin
                  // hole opens here; later entries move down one slot
                  if (tag_eq) begin
                     wr_ff <= pos_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         if (cmd_i.shift && rv_ff) begin
            wr_ff <= wr_ff + CNT_W'(1);
         end
      end
   end

   assign chosen_wide = {{TFLD_W{1'b0}}, chosen_ff};
   assign count_wide  = {{CFLD_W{1'b0}}, n_ff};

   always_ff @(posedge clock) begin
      if (cmd_i.emit) begin
         rsp_status_ff <= status_ff;
         rsp_tag_ff    <= chosen_wide[TFLD_W-1:0];
         rsp_hit_ff    <= hit_ff;
         rsp_count_ff  <= count_wide[CFLD_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_chosen_tag  = rsp_tag_ff;
   assign rsp_row_hit     = rsp_hit_ff;
   assign rsp_entry_count = rsp_count_ff;

   `ASSERT_NEXT(a_emit_shows, clock, reset, cmd_i.emit, rsp_valid_ff)
   `ASSERT_IMPL(a_read_in_queue, clock, reset, rv_ff, pos_ff < n_ff)
   `ASSERT_IMPL(a_shift_below_read, clock, reset, cmd_i.shift && rv_ff, wr_ff < pos_ff)

endmodule

/* hdl/fr_fcfs_bank_request_scheduler_unit.sv */
// -----------------------------------------------------------------------------
// FR-FCFS bank request scheduler: store, empty queue or bad bank skip the queue walk;
// select, query or missed remove scan the bank entries (at most QUEUE_DEPTH), and a remove
// that hits also shifts the later entries down over the hole.
// One request at a time; the result shows as req_ready rises for the next request.
// Synchronous reset empties every bank queue; queue slots themselves are not cleared.
// -----------------------------------------------------------------------------
module fr_fcfs_bank_request_scheduler_unit #(
   parameter int NUM_BANKS   = frfcfs_pkg::NUM_BANKS_DEF,
   parameter int QUEUE_DEPTH = frfcfs_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = frfcfs_pkg::TAG_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [frfcfs_pkg::MODE_W-1:0]       req_mode,
   input  logic [frfcfs_pkg::BANK_FLD_W-1:0]   req_bank,
   input  logic [frfcfs_pkg::ROW_W-1:0]        req_row,
   input  logic [frfcfs_pkg::TAG_FLD_W-1:0]    req_request_tag,
   input  logic                                req_bank_open,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [frfcfs_pkg::STATUS_W-1:0]     rsp_status,
   output logic [frfcfs_pkg::TAG_FLD_W-1:0]    rsp_chosen_tag,
   output logic                                rsp_row_hit,
   output logic [frfcfs_pkg::COUNT_FLD_W-1:0]  rsp_entry_count
);

   frfcfs_pkg::cmd_type  cmd;
   frfcfs_pkg::stat_type st;

   frfcfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st_i      (st),
      .cmd_o     (cmd)
   );

   frfcfs_dp #(
      .NUM_BANKS   (NUM_BANKS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_bank        (req_bank),
      .req_row         (req_row),
      .req_request_tag (req_request_tag),
      .req_bank_open   (req_bank_open),
      .cmd_i           (cmd),
      .st_o            (st),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_chosen_tag  (rsp_chosen_tag),
      .rsp_row_hit     (rsp_row_hit),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

/* verif/testbench.sv */
// -----------------------------------------------------------------------------
// FR-FCFS bank request scheduler testbench
// Drives store, remove, select and row-hit query requests through the request
// channel and checks every response against a per-bank queue predictor. The
// sender idles in bursts, the receiver stalls on its own pattern, and the
// random phases fill the bank queues up to full and then drain them again.
// -----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BANKS   = frfcfs_pkg::NUM_BANKS_DEF;
   localparam int DEPTH   = frfcfs_pkg::QUEUE_DEPTH_DEF;
   localparam int MODE_W  = frfcfs_pkg::MODE_W;
   localparam int BANK_W  = frfcfs_pkg::BANK_FLD_W;
   localparam int ROW_W   = frfcfs_pkg::ROW_W;
   localparam int TAG_W   = frfcfs_pkg::TAG_FLD_W;
   localparam int STAT_W  = frfcfs_pkg::STATUS_W;
   localparam int COUNT_W = frfcfs_pkg::COUNT_FLD_W;

   typedef struct {
      frfcfs_pkg::mode_type    mode;
      logic [BANK_W-1:0]       bank;
      logic [ROW_W-1:0]        row;
      logic [TAG_W-1:0]        tag;
      logic                    open;
   } sched_req_type;

   typedef struct {
      frfcfs_pkg::status_type  status;
      logic [TAG_W-1:0]        chosen_tag;
      logic                    row_hit;
      logic [COUNT_W-1:0]      entry_count;
   } sched_rsp_type;

   logic                    clock;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_ready;
   logic [MODE_W-1:0]       req_mode        = '0;
   logic [BANK_W-1:0]       req_bank        = '0;
   logic [ROW_W-1:0]        req_row         = '0;
   logic [TAG_W-1:0]        req_request_tag = '0;
   logic                    req_bank_open   = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready       = 1'b0;
   logic [STAT_W-1:0]       rsp_status;
   logic [TAG_W-1:0]        rsp_chosen_tag;
   logic                    rsp_row_hit;
   logic [COUNT_W-1:0]      rsp_entry_count;

   fr_fcfs_bank_request_scheduler_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_bank        (req_bank),
      .req_row         (req_row),
      .req_request_tag (req_request_tag),
      .req_bank_open   (req_bank_open),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_chosen_tag  (rsp_chosen_tag),
      .rsp_row_hit     (rsp_row_hit),
      .rsp_entry_count (rsp_entry_count)
   );

   // per-bank shadow queues, oldest entry at index 0
   logic [ROW_W-1:0]     shadow_row [BANKS][DEPTH];
   logic [TAG_W-1:0]     shadow_tag [BANKS][DEPTH];
   int                   shadow_len [BANKS];

   sched_req_type pending_requests[$];
   sched_rsp_type predicted_results[$];

   int accepted_cnt  = 0;
   int rsp_total     = 0;
   int mismatches    = 0;
   int full_rejects  = 0;
   int tag_misses    = 0;
   int hit_selects   = 0;
   int hit_queries   = 0;

   // append a request to the tail of the pending queue
   function automatic void queue_request(sched_req_type rq);
      pending_requests = {pending_requests, rq};
   endfunction

   function automatic sched_rsp_type schedule_step(sched_req_type rq);
      sched_rsp_type r;
      int b;
      int n;
      int k;
      int hits;
      bit found;
      r.status      = frfcfs_pkg::STATUS_DONE;
      r.chosen_tag  = '0;
      r.row_hit     = 1'b0;
      r.entry_count = '0;
      b = int'(rq.bank);
      if (b >= BANKS) begin
         r.status = frfcfs_pkg::STATUS_MISS;
         return r;
      end
      n = shadow_len[b];
      case (rq.mode)
         frfcfs_pkg::MODE_STORE: begin
            if (n >= DEPTH) begin
               r.status = frfcfs_pkg::STATUS_FULL;
               full_rejects++;
            end else begin
               shadow_row[b][n] = rq.row;
               shadow_tag[b][n] = rq.tag;
               n++;
            end
         end
         frfcfs_pkg::MODE_REMOVE: begin
            found = 1'b0;
            for (k = 0; k < n; k++) begin
               if (!found && shadow_tag[b][k] == rq.tag) found = 1'b1;
               // close the gap behind the removed entry
               if (found && k + 1 < n) begin
                  shadow_row[b][k] = shadow_row[b][k+1];
                  shadow_tag[b][k] = shadow_tag[b][k+1];
               end
            end
            if (found) n--;
            else begin
               r.status = frfcfs_pkg::STATUS_MISS;
               tag_misses++;
            end
         end
         frfcfs_pkg::MODE_SELECT: begin
            if (n == 0) r.status = frfcfs_pkg::STATUS_MISS;
            else begin
               r.chosen_tag = shadow_tag[b][0];
               if (rq.open) begin
                  for (k = n - 1; k >= 0; k--) begin
                     if (shadow_row[b][k] == rq.row) begin
                        r.chosen_tag = shadow_tag[b][k];
                        r.row_hit    = 1'b1;
                     end
                  end
               end
               if (r.row_hit) hit_selects++;
            end
         end
         default: begin
            hits = 0;
            for (k = 0; k < n; k++)
               if (shadow_row[b][k] == rq.row) hits++;
            r.row_hit = (hits >= 2);
            if (r.row_hit) hit_queries++;
         end
      endcase
      shadow_len[b] = n;
      r.entry_count = n[COUNT_W-1:0];
      return r;
   endfunction

   function automatic sched_req_type make_req(frfcfs_pkg::mode_type m, int bank, int row,
                                              int tag, bit open);
      sched_req_type rq;
      rq.mode = m;
      rq.bank = bank[BANK_W-1:0];
      rq.row  = row[ROW_W-1:0];
      rq.tag  = tag[TAG_W-1:0];
      rq.open = open;
      return rq;
   endfunction

   // random request; rows and tags mostly from small pools so hits and
   // duplicates are common, sometimes fully random
   function automatic sched_req_type random_req(int bank_hi, int w_store, int w_remove,
                                                int w_select);
      sched_req_type rq;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < w_store) rq.mode = frfcfs_pkg::MODE_STORE;
      else if (pick < w_store + w_remove) rq.mode = frfcfs_pkg::MODE_REMOVE;
      else if (pick < w_store + w_remove + w_select) rq.mode = frfcfs_pkg::MODE_SELECT;
      else rq.mode = frfcfs_pkg::MODE_QUERY;
      if ($urandom_range(0, 9) == 0) rq.bank = BANK_W'($urandom_range(0, BANKS - 1));
      else rq.bank = BANK_W'($urandom_range(0, bank_hi));
      if ($urandom_range(0, 3) == 0) rq.row = ROW_W'($urandom);
      else rq.row = ROW_W'($urandom_range(0, 5));
      if ($urandom_range(0, 3) == 0) rq.tag = TAG_W'($urandom_range(0, 255));
      else rq.tag = TAG_W'($urandom_range(0, 15));
      rq.open = ($urandom_range(0, 3) != 0);
      return rq;
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // request driver: bursts of transfers with random gaps
   int            burst_left = 0;
   int            gap_left   = 0;
   sched_req_type cur_req;

   always @(posedge clock) begin : drive_requests
      logic go;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_results = {predicted_results, schedule_step(cur_req)};
            accepted_cnt++;
         end
         // hold the payload until the transfer completes
         if (!req_valid || req_ready) begin
            go = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0) begin
               cur_req = pending_requests.pop_front();
               go      = 1'b1;
               req_mode        <= cur_req.mode;
               req_bank        <= cur_req.bank;
               req_row         <= cur_req.row;
               req_request_tag <= cur_req.tag;
               req_bank_open   <= cur_req.open;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
               end
            end
            req_valid <= go;
         end
      end
   end

   // response monitor and receiver stall pattern
   int rx_cycle  = 0;
   int hold_left = 0;

   always @(posedge clock) begin : collect_results
      sched_rsp_type want;
      logic rdy;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_total++;
            if (predicted_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] unexpected response: status %0d tag %0h hit %0d count %0d",
                           $realtime, rsp_status, rsp_chosen_tag, rsp_row_hit,
                           rsp_entry_count);
            end else begin
               want = predicted_results.pop_front();
               if (rsp_status !== want.status || rsp_chosen_tag !== want.chosen_tag ||
                   rsp_row_hit !== want.row_hit || rsp_entry_count !== want.entry_count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("[%0t] response %0d: expected status %0d tag %0h hit %0d count %0d",
                              $realtime, rsp_total, want.status, want.chosen_tag,
                              want.row_hit, want.entry_count);
                     $display("    actual status %0d tag %0h hit %0d count %0d",
                              rsp_status, rsp_chosen_tag, rsp_row_hit, rsp_entry_count);
                  end
               end
            end
            // long hold-off while the sender keeps offering requests
            if (rsp_total == 700) hold_left = 400;
         end
         rx_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else begin
            case ((rx_cycle / 300) % 4)
               0:       rdy = 1'b1;
               1:       rdy = (rx_cycle % 4) != 0;
               2:       rdy = 1'($urandom_range(0, 1));
               default: rdy = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_ready <= rdy;
      end
   end

   task automatic wait_idle();
      while (pending_requests.size() > 0 || req_valid || predicted_results.size() > 0)
         @(negedge clock);
   endtask

   task automatic run_phase(int count, int bank_hi, int w_store, int w_remove,
                            int w_select);
      int k;
      for (k = 0; k < count; k++)
         queue_request(random_req(bank_hi, w_store, w_remove, w_select));
      wait_idle();
   endtask

   initial begin
      int b;
      for (b = 0; b < BANKS; b++) shadow_len[b] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty bank: select, query and remove all miss or report nothing
      queue_request(make_req(frfcfs_pkg::MODE_SELECT, 0, 'h1234, 0, 1'b1));
      queue_request(make_req(frfcfs_pkg::MODE_QUERY,  0, 'h1234, 0, 1'b0));
      queue_request(make_req(frfcfs_pkg::MODE_REMOVE, 0, 0, 'h05, 1'b0));
      // field extremes, a repeated row and a duplicate tag
      queue_request(make_req(frfcfs_pkg::MODE_STORE,  0, 'h0000, 'h00, 1'b0));
      queue_request(make_req(frfcfs_pkg::MODE_STORE,  0, 'hFFFF, 'hFF, 1'b1));
      queue_request(make_req(frfcfs_pkg::MODE_STORE,  0, 'h1234, 'h10, 1'b0));
      queue_request(make_req(frfcfs_pkg::MODE_STORE,  0, 'h4321, 'h10, 1'b0));
      queue_request(make_req(frfcfs_pkg::MODE_STORE,  0, 'hFFFF, 'h20, 1'b0));
      // closed bank takes the oldest; open bank takes the oldest row hit
      queue_request(make_req(frfcfs_pkg::MODE_SELECT, 0, 'hFFFF, 0, 1'b0));
      queue_request(make_req(frfcfs_pkg::MODE_SELECT, 0, 'hFFFF, 0, 1'b1));
      queue_request(make_req(frfcfs_pkg::MODE_SELECT, 0, 'hAAAA, 0, 1'b1));
      queue_request(make_req(frfcfs_pkg::MODE_QUERY,  0, 'hFFFF, 0, 1'b0));
      queue_request(make_req(frfcfs_pkg::MODE_QUERY,  0, 'h0000, 0, 1'b1));
      // duplicate tag: oldest goes, then an absent tag, then the head
      queue_request(make_req(frfcfs_pkg::MODE_REMOVE, 0, 0, 'h10, 1'b0));
      queue_request(make_req(frfcfs_pkg::MODE_SELECT, 0, 'h4321, 0, 1'b1));
      queue_request(make_req(frfcfs_pkg::MODE_REMOVE, 0, 0, 'h77, 1'b0));
      queue_request(make_req(frfcfs_pkg::MODE_REMOVE, 0, 0, 'h00, 1'b0));
      queue_request(make_req(frfcfs_pkg::MODE_STORE,  15, 'h5555, 'hAA, 1'b0));
      queue_request(make_req(frfcfs_pkg::MODE_SELECT, 15, 'h5555, 0, 1'b1));
      queue_request(make_req(frfcfs_pkg::MODE_REMOVE, 15, 0, 'hAA, 1'b0));
      wait_idle();

      // fill a few banks past full, then mix, drain, and mix again
      run_phase(500, 3, 60, 10, 15);
      run_phase(700, BANKS - 1, 25, 25, 25);
      run_phase(400, 3, 15, 50, 20);
      run_phase(400, 7, 35, 35, 15);

      // let any stray response show up
      repeat (60) @(negedge clock);

      $display("Checked %0d responses to %0d requests across all four request kinds.",
               rsp_total, accepted_cnt);
      $display("Saw %0d full rejects, %0d tag misses, %0d hit selects, %0d hit queries.",
               full_rejects, tag_misses, hit_selects, hit_queries);
      if (mismatches == 0 && predicted_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timed out with %0d responses outstanding", predicted_results.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
